/* design/hsa_pkg.sv */
// Shared types and constants for the HSL saturation adjust pipeline.
`timescale 1ns / 1ps
package hsa_pkg;

  localparam int NUM_CH     = 3;
  localparam int DIV_STAGES = 4;
  localparam int NUM_STG    = 5 + DIV_STAGES;

  localparam logic [7:0] PCT_FULL = 8'd100;
  localparam logic [7:0] BYTE_MAX = 8'd255;

  localparam logic CFG_IDX_SAT = 1'b0;

  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] low;
    logic [7:0] quo;
  } div_t;

endpackage

/* design/hsa_div_stage.sv */
// Two restoring-division quotient bits per channel, registered.
`timescale 1ns / 1ps
module hsa_div_stage (
  input  logic        clk_i,
  input  logic        en_i,
  input  hsa_pkg::div_t div_i [hsa_pkg::NUM_CH],
  input  logic [8:0]  den_i,
  output hsa_pkg::div_t div_o [hsa_pkg::NUM_CH],
  output logic [8:0]  den_o
);

  hsa_pkg::div_t div_d [hsa_pkg::NUM_CH];
  hsa_pkg::div_t div_q [hsa_pkg::NUM_CH];
  logic [8:0]    den_q;

  function automatic hsa_pkg::div_t div_step(hsa_pkg::div_t x, logic [8:0] den);
    logic [9:0]    t;
    logic          ge;
    hsa_pkg::div_t y;
    t     = {x.rem, x.low[7]};
    ge    = (t >= {1'b0, den});
    y.rem = ge ? 9'(t - {1'b0, den}) : t[8:0];
    y.low = {x.low[6:0], 1'b0};
    y.quo = {x.quo[6:0], ge};
    return y;
  endfunction

  always_comb begin
    for (int k = 0; k < hsa_pkg::NUM_CH; k++) begin
      div_d[k] = div_step(div_step(div_i[k], den_i), den_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
      den_q <= den_i;
    end
  end

  assign div_o = div_q;
  assign den_o = den_q;

endmodule

/* design/hsl_saturation_adjust.sv */
// Top level: HSL saturation adjustment of one RGB pixel per clock when not stalled.
// One pixel enters per clock while in_stall_o is low and passes through a
// 9-stage pipeline (input register, min/max, branch select, multiply, sum,
// then a 4-stage restoring divider giving two quotient bits per stage). Each
// stage advances whenever the stage after it is empty or moving, so bubbles
// collapse under output stall. saturation_percent lives at byte address 0 and
// is to be written only while the pipeline is empty.
`timescale 1ns / 1ps
module hsl_saturation_adjust (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o
);

  localparam int NS = hsa_pkg::NUM_STG;
  localparam int NC = hsa_pkg::NUM_CH;
  localparam int ND = hsa_pkg::DIV_STAGES;

  // config
  logic signed [7:0] sat_q;
  logic signed [7:0] pc;

  assign pready = 1'b1;
  assign prdata = {{24{sat_q[7]}}, sat_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == hsa_pkg::CFG_IDX_SAT) begin
      sat_q <= pwdata[7:0];
    end
  end

  always_comb begin
    if (sat_q < -8'sd100) begin
      pc = -8'sd100;
    end else if (sat_q > 8'sd100) begin
      pc = 8'sd100;
    end else begin
      pc = sat_q;
    end
  end

  // flow control
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NS-1];

  // stage 1: input register
  logic [7:0] c1_q [NC];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      c1_q[0] <= red_in_i;
      c1_q[1] <= green_in_i;
      c1_q[2] <= blue_in_i;
    end
  end

  // stage 2: max, min, lightness denominator
  logic [7:0] mx, mn, dlt;
  logic [8:0] sum;
  logic [7:0] den;
  logic [7:0] c2_q [NC];
  logic [8:0] sum2_q;
  logic [7:0] d2_q, den2_q;
  logic       gray2_q;

  always_comb begin
    mx = c1_q[0];
    mn = c1_q[0];
    for (int k = 1; k < NC; k++) begin
      if (c1_q[k] > mx) mx = c1_q[k];
      if (c1_q[k] < mn) mn = c1_q[k];
    end
    dlt = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    den = (sum < {1'b0, hsa_pkg::BYTE_MAX}) ? sum[7:0]
                                             : 8'(10'd510 - {1'b0, sum});
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      c2_q    <= c1_q;
      sum2_q  <= sum;
      d2_q    <= dlt;
      den2_q  <= den;
      gray2_q <= (dlt == 8'd0);
    end
  end

  // stage 3: pick alpha as an / ad
  logic [6:0]  pu;
  logic [14:0] lhs, rhs;
  logic        cut;
  logic [7:0]  an, ad;
  logic [7:0]  c3_q [NC];
  logic [8:0]  sum3_q;
  logic [7:0]  an3_q, ad3_q;
  logic        cut3_q, gray3_q;

  always_comb begin
    pu  = pc[6:0];
    cut = pc[7];
    lhs = 15'(pu * den2_q);
    rhs = 15'(hsa_pkg::PCT_FULL[6:0] * (den2_q - d2_q));
    if (cut) begin
      an = 8'(9'(signed'({1'b0, hsa_pkg::PCT_FULL})) + 9'(pc));
      ad = hsa_pkg::PCT_FULL;
    end else if (lhs >= rhs) begin
      an = den2_q - d2_q;
      ad = d2_q;
    end else begin
      an = {1'b0, pu};
      ad = hsa_pkg::PCT_FULL - {1'b0, pu};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c3_q    <= c2_q;
      sum3_q  <= sum2_q;
      an3_q   <= an;
      ad3_q   <= ad;
      cut3_q  <= cut;
      gray3_q <= gray2_q;
    end
  end

  // stage 4: products
  logic signed [10:0] diff [NC];
  logic signed [19:0] prod [NC];
  logic        [16:0] base [NC];
  logic signed [19:0] prod4_q [NC];
  logic        [16:0] base4_q [NC];
  logic        [7:0]  c4_q [NC];
  logic        [8:0]  dd4_q;
  logic               gray4_q;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      diff[k] = $signed({2'b0, c3_q[k], 1'b0}) - $signed({2'b0, sum3_q});
      prod[k] = 20'(diff[k] * $signed({1'b0, an3_q}));
      base[k] = cut3_q ? 17'(sum3_q * hsa_pkg::PCT_FULL)
                       : 17'({c3_q[k], 1'b0} * ad3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      prod4_q <= prod;
      base4_q <= base;
      c4_q    <= c3_q;
      dd4_q   <= {ad3_q, 1'b0};
      gray4_q <= gray3_q;
    end
  end

  // stage 5: numerator, sign and range check, divider setup
  logic signed [20:0] num [NC];
  logic        [16:0] dsh;
  logic        [16:0] nsel [NC];
  hsa_pkg::div_t      div0 [NC];
  hsa_pkg::div_t      divq [ND+1][NC];
  logic        [8:0]  denq [ND+1];
  logic        [8:0]  den5;

  always_comb begin
    dsh  = {dd4_q, 8'd0};
    den5 = gray4_q ? 9'd1 : dd4_q;
    for (int k = 0; k < NC; k++) begin
      num[k] = $signed({4'b0, base4_q[k]}) + 21'(prod4_q[k]);
      if (gray4_q) begin
        nsel[k] = {9'd0, c4_q[k]};
      end else if (num[k][20]) begin
        nsel[k] = '0;
      end else if (num[k][19:0] >= {3'b0, dsh}) begin
        nsel[k] = dsh - {8'd0, dd4_q};
      end else begin
        nsel[k] = num[k][16:0];
      end
      div0[k].rem = nsel[k][16:8];
      div0[k].low = nsel[k][7:0];
      div0[k].quo = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      divq[0] <= div0;
      denq[0] <= den5;
    end
  end

  // stages 6..9: divider
  for (genvar g = 0; g < ND; g++) begin : g_div
    hsa_div_stage u_div (
      .clk_i (clk_i),
      .en_i  (en[5+g]),
      .div_i (divq[g]),
      .den_i (denq[g]),
      .div_o (divq[g+1]),
      .den_o (denq[g+1])
    );
  end

  assign red_out_o   = divq[ND][0].quo;
  assign green_out_o = divq[ND][1].quo;
  assign blue_out_o  = divq[ND][2].quo;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with an empty stage");

  a_div_rem_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (divq[0][0].rem < denq[0] && divq[0][1].rem < denq[0]
                && divq[0][2].rem < denq[0]))
    else $error("divider entry remainder not below divisor");

  a_div_rem_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] |-> (divq[ND][0].rem < denq[ND] && divq[ND][1].rem < denq[ND]
                   && divq[ND][2].rem < denq[ND]))
    else $error("divider exit remainder not below divisor");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for hsl_saturation_adjust: directed and random pixels.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 3 * hsa_pkg::NUM_STG;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  red_in_i = '0;
  logic [7:0]  green_in_i = '0;
  logic [7:0]  blue_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;

  logic signed [7:0] sat_pct;
  pixel_t            pending_pixels[$];
  int                n_errors;
  int                n_pixels;
  int                n_checked;
  int                n_cycles;
  bit                allow_idle;

  hsl_saturation_adjust dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [7:0] clamp_quot(longint num, longint den);
    longint q;
    if (num < 0) return 8'd0;
    q = num / den;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic pixel_t adjust_saturation(pixel_t px, logic signed [7:0] pct);
    longint ch[3];
    longint mx, mn, sum, span, den, p, an, ad;
    pixel_t res;
    logic [7:0] o[3];
    ch[0] = px.r; ch[1] = px.g; ch[2] = px.b;
    mx = ch[0]; mn = ch[0];
    for (int k = 1; k < 3; k++) begin
      if (ch[k] > mx) mx = ch[k];
      if (ch[k] < mn) mn = ch[k];
    end
    span = mx - mn;
    if (span == 0) return px;
    sum = mx + mn;
    den = (sum < 255) ? sum : (510 - sum);
    p = pct;
    if (p < -100) p = -100;
    if (p > 100) p = 100;
    for (int k = 0; k < 3; k++) begin
      if (p >= 0) begin
        if (p * den + 100 * span >= 100 * den) begin
          an = den - span; ad = span;
        end else begin
          an = p; ad = 100 - p;
        end
        o[k] = clamp_quot(2 * ch[k] * ad + (2 * ch[k] - sum) * an, 2 * ad);
      end else begin
        o[k] = clamp_quot(sum * 100 + (2 * ch[k] - sum) * (100 + p), 200);
      end
    end
    res.r = o[0]; res.g = o[1]; res.b = o[2];
    return res;
  endfunction

  // output stall bursts
  always @(posedge clk_i) begin
    if (allow_idle && $urandom_range(0, 9) == 0)
      out_stall_i <= 1'b1;
    else if (!allow_idle || $urandom_range(0, 3) == 0)
      out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_checked++;
      if (pending_pixels.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected beat %h %h %h", red_out_o, green_out_o, blue_out_o);
      end else begin
        want = pending_pixels.pop_front();
        if (want.r !== red_out_o || want.g !== green_out_o || want.b !== blue_out_o) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected %h %h %h, got %h %h %h", want.r, want.g, want.b,
                     red_out_o, green_out_o, blue_out_o);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_percent(logic signed [7:0] pct);
    logic [31:0] rd;
    wait_drained();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {{24{pct[7]}}, pct};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sat_pct = pct;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel <= 1'b0; penable <= 1'b0;
    if (rd[7:0] !== pct) begin
      n_errors++;
      if (n_errors <= 10) $display("readback: expected %h, got %h", pct, rd[7:0]);
    end
  endtask

  task automatic send_pixel(pixel_t px);
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i <= px.r; green_in_i <= px.g; blue_in_i <= px.b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_pixels.push_back(adjust_saturation(px, sat_pct));
    n_pixels++;
  endtask

  task automatic end_stream();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px = 24'($urandom);
    case ($urandom_range(0, 5))
      0: px.g = px.r;
      1: begin px.g = px.r; px.b = px.r; end
      2: begin px.r = 8'd255; px.b = 8'd0; end
      default: ;
    endcase
    return px;
  endfunction

  task automatic test_directed();
    pixel_t corners[8];
    logic signed [7:0] pcts[6];
    corners[0] = 24'h000000; corners[1] = 24'hffffff; corners[2] = 24'hff0000;
    corners[3] = 24'h00ff00; corners[4] = 24'h0000ff; corners[5] = 24'h808080;
    corners[6] = 24'hfe0180; corners[7] = 24'h7f8081;
    pcts[0] = 8'sd0; pcts[1] = 8'sd100; pcts[2] = -8'sd100;
    pcts[3] = 8'sd127; pcts[4] = -8'sd128; pcts[5] = 8'sd50;
    foreach (pcts[i]) begin
      write_percent(pcts[i]);
      foreach (corners[j]) send_pixel(corners[j]);
      end_stream();
    end
  endtask

  task automatic test_random(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 0) begin
        end_stream();
        write_percent(8'($urandom_range(0, 3) == 0 ? $urandom
                                                    : $urandom_range(0, 200) - 100));
      end
      send_pixel(rand_pixel());
    end
    end_stream();
  endtask

  task automatic test_back_to_back(int n_items);
    allow_idle = 1'b0;
    write_percent(-8'sd37);
    for (int i = 0; i < n_items; i++) send_pixel(rand_pixel());
    end_stream();
  endtask

  initial begin
    sat_pct = '0;
    allow_idle = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(450);
    test_back_to_back(60);
    wait_drained();
    $display("sent %0d pixels, checked %0d results", n_pixels, n_checked);
    $display("covered percent extremes, out-of-range settings, gray and saturated pixels");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("error count %0d", n_errors);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
